@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the text screen engine. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ACTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("acts: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ACTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("acts: assertion failed");
`else
`define ACTS_ASSERT(lbl, clk, rstn, prop)
`define ACTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/acts_pkg.sv @@
// ----------------------------------------------------------------------------
// acts_pkg
// Types, constants and the SGR helper function shared by the text screen engine.
// ----------------------------------------------------------------------------
package acts_pkg;

  localparam int MaxColumns = 128;
  localparam int MaxRows    = 64;
  localparam int MaxParams  = 16;
  localparam int QueueDepth = 2;

  localparam int ColW      = $clog2(MaxColumns);
  localparam int RowW      = $clog2(MaxRows);
  localparam int ColsW     = 8;
  localparam int RowsW     = 7;
  localparam int CellW     = 21;
  localparam int AttrW     = 13;
  localparam int ParamW    = 16;
  localparam int ParamIdxW = $clog2(MaxParams);
  localparam int ParamCntW = ParamIdxW + 1;
  localparam int QPtrW     = $clog2(QueueDepth);
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 8;

  localparam logic [ColsW-1:0] ColsReset = 8'd80;
  localparam logic [RowsW-1:0] RowsReset = 7'd24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1
  } cfg_reg_e;

  // Byte codes of the terminal stream.
  localparam logic [7:0] ChEsc      = 8'h1B;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChLf       = 8'h0A;
  localparam logic [7:0] ChBs       = 8'h08;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChCsiOpen  = 8'h5B;
  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChSemi     = 8'h3B;
  localparam logic [7:0] ChDigit0   = 8'h30;
  localparam logic [7:0] ChDigit9   = 8'h39;
  localparam logic [7:0] FinalLow   = 8'h40;
  localparam logic [7:0] FinalHigh  = 8'h7E;
  localparam logic [7:0] FinalCuu   = 8'h41;
  localparam logic [7:0] FinalCud   = 8'h42;
  localparam logic [7:0] FinalCuf   = 8'h43;
  localparam logic [7:0] FinalCub   = 8'h44;
  localparam logic [7:0] FinalCup   = 8'h48;
  localparam logic [7:0] FinalHvp   = 8'h66;
  localparam logic [7:0] FinalEd    = 8'h4A;
  localparam logic [7:0] FinalEl    = 8'h4B;
  localparam logic [7:0] FinalSgr   = 8'h6D;
  localparam logic [7:0] FinalSet   = 8'h68;
  localparam logic [7:0] FinalReset = 8'h6C;

  localparam logic [ParamW-1:0] ModeCursor = 16'd25;
  localparam logic [ParamW-1:0] ParamSat   = 16'hFFFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [5:0] read_row;
    logic [6:0] read_column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [4:0] cell_fg;
    logic [4:0] cell_bg;
    logic       cell_bold;
    logic       cell_underline;
    logic       cell_inverse;
    logic [5:0] cursor_row_out;
    logic [6:0] cursor_column_out;
    logic       cursor_shown;
    logic       wrap_pending;
    logic       scrolled;
  } out_item_t;

  typedef struct packed {
    logic       inverse;
    logic       underline;
    logic       bold;
    logic [4:0] bg;
    logic [4:0] fg;
  } attr_t;

  typedef struct packed {
    attr_t      attr;
    logic [7:0] ch;
  } cell_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_READ,
    OP_PRINT,
    OP_CR,
    OP_LF,
    OP_BS,
    OP_UP,
    OP_DOWN,
    OP_RIGHT,
    OP_LEFT,
    OP_SETPOS,
    OP_ERASE_DISP,
    OP_ERASE_LINE,
    OP_SHOW,
    OP_HIDE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [7:0]        ch;
    attr_t             attr;
    logic [ParamW-1:0] arg0;
    logic [ParamW-1:0] arg1;
    logic [RowW-1:0]   rd_row;
    logic [ColW-1:0]   rd_col;
  } cmd_t;

  // One SGR parameter applied to the running attribute set.
  function automatic attr_t sgr_apply(attr_t a, logic [ParamW-1:0] p);
    attr_t r;
    r = a;
    priority if (p == 16'd0) begin
      r = '0;
    end else if (p == 16'd1) begin
      r.bold = 1'b1;
    end else if (p == 16'd4) begin
      r.underline = 1'b1;
    end else if (p == 16'd7) begin
      r.inverse = 1'b1;
    end else if (p == 16'd22) begin
      r.bold = 1'b0;
    end else if (p == 16'd24) begin
      r.underline = 1'b0;
    end else if (p == 16'd27) begin
      r.inverse = 1'b0;
    end else if (p >= 16'd30 && p <= 16'd37) begin
      r.fg = 5'(p - 16'd29);
    end else if (p == 16'd39) begin
      r.fg = '0;
    end else if (p >= 16'd40 && p <= 16'd47) begin
      r.bg = 5'(p - 16'd39);
    end else if (p == 16'd49) begin
      r.bg = '0;
    end else if (p >= 16'd90 && p <= 16'd97) begin
      r.fg = 5'(p - 16'd81);
    end else if (p >= 16'd100 && p <= 16'd107) begin
      r.bg = 5'(p - 16'd91);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/acts_ram.sv @@
// ----------------------------------------------------------------------------
// acts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module acts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/acts_front.sv @@
// ----------------------------------------------------------------------------
// acts_front
// Byte parser: ground, ESC and CSI phases, parameter collection and SGR.
// Turns every accepted item into one command for the execution side.
// ----------------------------------------------------------------------------
module acts_front import acts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_stall_o,
  input  logic     hold_i,
  input  logic     q_full_i,
  output logic     push_o,
  output cmd_t     push_cmd_o
);

  typedef enum logic [1:0] {PH_GROUND, PH_ESC, PH_CSI} phase_e;
  typedef enum logic {F_RUN, F_SGR} fstate_e;

  phase_e                phase_q, phase_d;
  fstate_e               fstate_q, fstate_d;
  logic [ParamW-1:0]     store_q [MaxParams];
  logic [ParamCntW-1:0]  count_q, count_d;
  logic [ParamW-1:0]     accum_q, accum_d;
  logic                  seen_q, seen_d;
  logic                  priv_q, priv_d;
  attr_t                 attr_q, attr_d;
  logic [ParamCntW-1:0]  sgr_idx_q, sgr_idx_d;

  logic                  accept;
  logic                  st_we;
  logic [7:0]            b;
  logic [ParamW-1:0]     cur_val, first, second, n_val;
  logic                  can_store;
  logic [ParamW+3:0]     digit_sum;
  cmd_t                  cmd;

  assign in_stall_o = (fstate_q != F_RUN) || q_full_i || hold_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign b          = in_data_i.data_byte;
  assign cur_val    = seen_q ? accum_q : '0;
  assign can_store  = count_q < ParamCntW'(MaxParams);
  // At a final byte the value in progress becomes the next stored parameter.
  assign first      = (count_q == '0) ? cur_val : store_q[0];
  assign second     = (count_q == ParamCntW'(1)) ? cur_val : store_q[1];
  assign n_val      = (first == '0) ? ParamW'(1) : first;
  assign digit_sum  = {1'b0, accum_q, 3'b0} + {3'b0, accum_q, 1'b0}
                    + {16'b0, 4'(b - ChDigit0)};

  always_comb begin
    phase_d   = phase_q;
    fstate_d  = fstate_q;
    count_d   = count_q;
    accum_d   = accum_q;
    seen_d    = seen_q;
    priv_d    = priv_q;
    attr_d    = attr_q;
    sgr_idx_d = sgr_idx_q;
    st_we     = 1'b0;
    push_o    = 1'b0;
    cmd        = '0;
    cmd.op     = OP_NOP;
    cmd.ch     = b;
    cmd.attr   = attr_q;
    cmd.arg0   = n_val;
    cmd.rd_row = in_data_i.read_row;
    cmd.rd_col = in_data_i.read_column;

    if (fstate_q == F_SGR) begin
      if (sgr_idx_q < count_q) begin
        attr_d    = sgr_apply(attr_q, store_q[sgr_idx_q[ParamIdxW-1:0]]);
        sgr_idx_d = sgr_idx_q + 1'b1;
      end else if (!q_full_i) begin
        push_o   = 1'b1;
        fstate_d = F_RUN;
      end
    end else if (accept) begin
      push_o = 1'b1;
      if (in_data_i.kind) begin
        cmd.op = OP_READ;
      end else begin
        unique case (phase_q)
          PH_ESC: begin
            if (b == ChCsiOpen) begin
              phase_d = PH_CSI;
              count_d = '0;
              accum_d = '0;
              seen_d  = 1'b0;
              priv_d  = 1'b0;
            end else begin
              phase_d = PH_GROUND;
            end
          end
          PH_CSI: begin
            priority if (b == ChQuestion && count_q == '0 && !seen_q) begin
              priv_d = 1'b1;
            end else if (b >= ChDigit0 && b <= ChDigit9) begin
              accum_d = (digit_sum > {4'b0, ParamSat}) ? ParamSat : digit_sum[ParamW-1:0];
              seen_d  = 1'b1;
            end else if (b == ChSemi || (b >= FinalLow && b <= FinalHigh)) begin
              if (can_store) begin
                st_we   = 1'b1;
                count_d = count_q + 1'b1;
              end
              accum_d = '0;
              seen_d  = 1'b0;
              if (b != ChSemi) begin
                phase_d = PH_GROUND;
                case (b)
                  FinalCuu: cmd.op = OP_UP;
                  FinalCud: cmd.op = OP_DOWN;
                  FinalCuf: cmd.op = OP_RIGHT;
                  FinalCub: cmd.op = OP_LEFT;
                  FinalCup, FinalHvp: begin
                    cmd.op   = OP_SETPOS;
                    cmd.arg0 = n_val - 1'b1;
                    cmd.arg1 = (count_q != '0 && second != '0) ? second - 1'b1 : '0;
                  end
                  FinalEd: begin
                    cmd.op   = OP_ERASE_DISP;
                    cmd.arg0 = first;
                  end
                  FinalEl: begin
                    cmd.op   = OP_ERASE_LINE;
                    cmd.arg0 = first;
                  end
                  FinalSgr: begin
                    // The attribute update walks the stored list first.
                    push_o    = 1'b0;
                    fstate_d  = F_SGR;
                    sgr_idx_d = '0;
                  end
                  FinalSet: cmd.op = (priv_q && first == ModeCursor) ? OP_SHOW : OP_NOP;
                  FinalReset: cmd.op = (priv_q && first == ModeCursor) ? OP_HIDE : OP_NOP;
                  default: cmd.op = OP_NOP;
                endcase
              end
            end
          end
          PH_GROUND: begin
            priority if (b == ChEsc) begin
              phase_d = PH_ESC;
            end else if (b == ChCr) begin
              cmd.op = OP_CR;
            end else if (b == ChLf) begin
              cmd.op = OP_LF;
            end else if (b == ChBs) begin
              cmd.op = OP_BS;
            end else if (b >= ChSpace) begin
              cmd.op = OP_PRINT;
            end
          end
          default: phase_d = PH_GROUND;
        endcase
      end
    end
  end

  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_GROUND;
      fstate_q  <= F_RUN;
      count_q   <= '0;
      accum_q   <= '0;
      seen_q    <= 1'b0;
      priv_q    <= 1'b0;
      attr_q    <= '0;
      sgr_idx_q <= '0;
    end else begin
      phase_q   <= phase_d;
      fstate_q  <= fstate_d;
      count_q   <= count_d;
      accum_q   <= accum_d;
      seen_q    <= seen_d;
      priv_q    <= priv_d;
      attr_q    <= attr_d;
      sgr_idx_q <= sgr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_q[count_q[ParamIdxW-1:0]] <= cur_val;
    end
  end

endmodule

@@ rtl/core/acts_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// acts_cmd_queue
// Short in-order command queue between the parser and the execution side.
// ----------------------------------------------------------------------------
module acts_cmd_queue import acts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t             entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPtrW + 1)'(QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/core/acts_back.sv @@
// ----------------------------------------------------------------------------
// acts_back
// Command execution: cursor, scrolling, cell writes, raster erase engine,
// cell reads and the result register. Holds the size registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acts_back import acts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                q_empty_i,
  input  cmd_t                q_head_i,
  output logic                pop_o,
  output logic                hold_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  localparam int Depth = MaxRows * MaxColumns;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [1:0] {S_IDLE, S_FILL, S_PRINT, S_DONE} state_e;
  typedef enum logic [1:0] {C_DONE, C_PRINT, C_NONE} cont_e;

  state_e            state_q, state_d;
  cont_e             cont_q, cont_d;
  cmd_t              cmd_q, cmd_d;
  logic [RowsW-1:0]  rows_q, rows_d;
  logic [ColsW-1:0]  cols_q, cols_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  logic              wrap_q, wrap_d;
  logic              vis_q, vis_d;
  logic [RowW-1:0]   top_q, top_d;
  logic              scr_q, scr_d;
  logic              cell_ok_q, cell_ok_d;
  logic [RowW-1:0]   fr_q, fr_d, er_q, er_d;
  logic [ColW-1:0]   fc_q, fc_d, ec_q, ec_d, le_q, le_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [CellW-1:0]  wdata, rdata;
  logic [RowW-1:0]   last_row, rd_phys;
  logic [ColW-1:0]   last_col;
  logic              at_bottom;
  logic [ParamW:0]   sum_row, sum_col;
  logic [ColsW-1:0]  new_cols;
  logic [RowsW-1:0]  new_rows;
  cell_t             rd_cell;

  assign last_row  = RowW'(rows_q - 1'b1);
  assign last_col  = ColW'(cols_q - 1'b1);
  assign at_bottom = (RowsW'(row_q) + 1'b1) >= rows_q;
  assign rd_phys   = top_q + q_head_i.rd_row;
  assign raddr     = {rd_phys, q_head_i.rd_col};
  assign sum_row   = (ParamW + 1)'(row_q) + (ParamW + 1)'(q_head_i.arg0);
  assign sum_col   = (ParamW + 1)'(col_q) + (ParamW + 1)'(q_head_i.arg0);
  assign new_cols  = (cfg_data_i == '0) ? ColsW'(1) :
                     (cfg_data_i > CfgDataW'(MaxColumns)) ? ColsW'(MaxColumns) : cfg_data_i;
  assign new_rows  = (cfg_data_i[RowsW-1:0] == '0) ? RowsW'(1) :
                     (cfg_data_i[RowsW-1:0] > RowsW'(MaxRows)) ? RowsW'(MaxRows) :
                     cfg_data_i[RowsW-1:0];
  assign rd_cell   = cell_t'(rdata);

  always_comb begin
    state_d     = state_q;
    cont_d      = cont_q;
    cmd_d       = cmd_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    row_d       = row_q;
    col_d       = col_q;
    wrap_d      = wrap_q;
    vis_d       = vis_q;
    top_d       = top_q;
    scr_d       = scr_q;
    cell_ok_d   = cell_ok_q;
    fr_d        = fr_q;
    fc_d        = fc_q;
    er_d        = er_q;
    ec_d        = ec_q;
    le_d        = le_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = {RowW'(top_q + fr_q), fc_q};
    wdata       = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i && !out_valid_q) begin
          pop_o     = 1'b1;
          cmd_d     = q_head_i;
          scr_d     = 1'b0;
          state_d   = S_DONE;
          cont_d    = C_DONE;
          le_d      = last_col;
          unique case (q_head_i.op)
            OP_READ: begin
              cell_ok_d = (RowsW'(q_head_i.rd_row) < rows_q)
                       && (ColsW'(q_head_i.rd_col) < cols_q);
            end
            OP_PRINT: begin
              state_d = S_PRINT;
              if (wrap_q) begin
                wrap_d = 1'b0;
                col_d  = '0;
                if (at_bottom) begin
                  // Scroll: the new bottom line is cleared across the full row.
                  top_d   = top_q + 1'b1;
                  scr_d   = 1'b1;
                  fr_d    = last_row;
                  er_d    = last_row;
                  fc_d    = '0;
                  ec_d    = ColW'(MaxColumns - 1);
                  le_d    = ColW'(MaxColumns - 1);
                  cont_d  = C_PRINT;
                  state_d = S_FILL;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end
            end
            OP_LF: begin
              wrap_d = 1'b0;
              if (at_bottom) begin
                top_d   = top_q + 1'b1;
                scr_d   = 1'b1;
                fr_d    = last_row;
                er_d    = last_row;
                fc_d    = '0;
                ec_d    = ColW'(MaxColumns - 1);
                le_d    = ColW'(MaxColumns - 1);
                state_d = S_FILL;
              end else begin
                row_d = row_q + 1'b1;
              end
            end
            OP_CR: begin
              wrap_d = 1'b0;
              col_d  = '0;
            end
            OP_BS: begin
              wrap_d = 1'b0;
              if (col_q != '0) begin
                col_d = col_q - 1'b1;
              end
            end
            OP_UP: begin
              wrap_d = 1'b0;
              row_d  = (q_head_i.arg0 > ParamW'(row_q)) ? '0 :
                       row_q - q_head_i.arg0[RowW-1:0];
            end
            OP_DOWN: begin
              wrap_d = 1'b0;
              row_d  = (sum_row > (ParamW + 1)'(last_row)) ? last_row : sum_row[RowW-1:0];
            end
            OP_RIGHT: begin
              wrap_d = 1'b0;
              col_d  = (sum_col > (ParamW + 1)'(last_col)) ? last_col : sum_col[ColW-1:0];
            end
            OP_LEFT: begin
              wrap_d = 1'b0;
              col_d  = (q_head_i.arg0 > ParamW'(col_q)) ? '0 :
                       col_q - q_head_i.arg0[ColW-1:0];
            end
            OP_SETPOS: begin
              wrap_d = 1'b0;
              row_d  = (q_head_i.arg0 > ParamW'(last_row)) ? last_row :
                       q_head_i.arg0[RowW-1:0];
              col_d  = (q_head_i.arg1 > ParamW'(last_col)) ? last_col :
                       q_head_i.arg1[ColW-1:0];
            end
            OP_ERASE_DISP: begin
              // Erase regions are one raster run from a start to an end cell.
              if (q_head_i.arg0 == ParamW'(0)) begin
                fr_d = row_q;  fc_d = col_q;  er_d = last_row;  ec_d = last_col;
                state_d = S_FILL;
              end else if (q_head_i.arg0 == ParamW'(1)) begin
                fr_d = '0;  fc_d = '0;  er_d = row_q;  ec_d = col_q;
                state_d = S_FILL;
              end else if (q_head_i.arg0 == ParamW'(2)) begin
                fr_d = '0;  fc_d = '0;  er_d = last_row;  ec_d = last_col;
                state_d = S_FILL;
              end
            end
            OP_ERASE_LINE: begin
              fr_d = row_q;
              er_d = row_q;
              if (q_head_i.arg0 == ParamW'(0)) begin
                fc_d = col_q;  ec_d = last_col;
                state_d = S_FILL;
              end else if (q_head_i.arg0 == ParamW'(1)) begin
                fc_d = '0;  ec_d = col_q;
                state_d = S_FILL;
              end else if (q_head_i.arg0 == ParamW'(2)) begin
                fc_d = '0;  ec_d = last_col;
                state_d = S_FILL;
              end
            end
            OP_SHOW: vis_d = 1'b1;
            OP_HIDE: vis_d = 1'b0;
            default: ;
          endcase
        end
      end
      S_FILL: begin
        we = 1'b1;
        if (fr_q == er_q && fc_q == ec_q) begin
          unique case (cont_q)
            C_PRINT: state_d = S_PRINT;
            C_DONE:  state_d = S_DONE;
            default: state_d = S_IDLE;
          endcase
        end else if (fc_q == le_q) begin
          fr_d = fr_q + 1'b1;
          fc_d = '0;
        end else begin
          fc_d = fc_q + 1'b1;
        end
      end
      S_PRINT: begin
        we    = 1'b1;
        waddr = {RowW'(top_q + row_q), col_q};
        wdata = {cmd_q.attr, cmd_q.ch};
        if ((ColsW'(col_q) + 1'b1) >= cols_q) begin
          wrap_d = 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        out_d                   = '0;
        if (cmd_q.op == OP_READ && cell_ok_q) begin
          out_d.cell_char      = rd_cell.ch;
          out_d.cell_fg        = rd_cell.attr.fg;
          out_d.cell_bg        = rd_cell.attr.bg;
          out_d.cell_bold      = rd_cell.attr.bold;
          out_d.cell_underline = rd_cell.attr.underline;
          out_d.cell_inverse   = rd_cell.attr.inverse;
        end
        out_d.cursor_row_out    = row_q;
        out_d.cursor_column_out = col_q;
        out_d.cursor_shown      = vis_q;
        out_d.wrap_pending      = wrap_q;
        out_d.scrolled          = scr_q;
        out_valid_d             = 1'b1;
        state_d                 = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // A size write blanks the whole memory and restarts any clearing pass.
    if (cfg_valid_i && (cfg_index_i == CFG_COLUMNS || cfg_index_i == CFG_ROWS)) begin
      if (cfg_index_i == CFG_COLUMNS) begin
        cols_d = new_cols;
        if (ColsW'(col_q) >= new_cols) begin
          col_d = ColW'(new_cols - 1'b1);
        end
      end else begin
        rows_d = new_rows;
        if (RowsW'(row_q) >= new_rows) begin
          row_d = RowW'(new_rows - 1'b1);
        end
      end
      top_d   = '0;
      wrap_d  = 1'b0;
      fr_d    = '0;
      fc_d    = '0;
      er_d    = RowW'(MaxRows - 1);
      ec_d    = ColW'(MaxColumns - 1);
      le_d    = ColW'(MaxColumns - 1);
      cont_d  = C_NONE;
      state_d = S_FILL;
    end
  end

  assign hold_o      = (state_q == S_FILL) && (cont_q == C_NONE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      cont_q      <= C_NONE;
      rows_q      <= RowsReset;
      cols_q      <= ColsReset;
      row_q       <= '0;
      col_q       <= '0;
      wrap_q      <= 1'b0;
      vis_q       <= 1'b1;
      top_q       <= '0;
      scr_q       <= 1'b0;
      cell_ok_q   <= 1'b0;
      fr_q        <= '0;
      fc_q        <= '0;
      er_q        <= RowW'(MaxRows - 1);
      ec_q        <= ColW'(MaxColumns - 1);
      le_q        <= ColW'(MaxColumns - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cont_q      <= cont_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      row_q       <= row_d;
      col_q       <= col_d;
      wrap_q      <= wrap_d;
      vis_q       <= vis_d;
      top_q       <= top_d;
      scr_q       <= scr_d;
      cell_ok_q   <= cell_ok_d;
      fr_q        <= fr_d;
      fc_q        <= fc_d;
      er_q        <= er_d;
      ec_q        <= ec_d;
      le_q        <= le_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  acts_ram #(
    .Width(CellW),
    .Depth(Depth)
  ) u_screen_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  `ACTS_ASSERT(a_row_in_screen, clk_i, rst_ni, RowsW'(row_q) < rows_q)
  `ACTS_ASSERT(a_col_in_screen, clk_i, rst_ni, ColsW'(col_q) < cols_q)
  `ACTS_ASSERT_NEXT(a_pop_leaves_idle, clk_i, rst_ni, pop_o, state_q != S_IDLE)

endmodule

@@ rtl/core/ansi_csi_text_screen_top.sv @@
// ----------------------------------------------------------------------------
// ansi_csi_text_screen_top
// Text terminal screen engine: escape parser, command queue and executor.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_stall  in_item_t (byte feed or cell read)
//   out      output     out_valid/out_stall out_item_t (cell, cursor, status)
//   cfg      input      cfg_valid/ready    register index and write data
//
// A simple byte or cursor command passes the executor's idle and done states,
// as does a cell read; a printable byte also takes the print state. An erase
// walks the cleared cells in raster order, one write each, and a scroll also
// clears every cell of the full row. After reset and after each size write a
// clearing pass sweeps all MaxRows*MaxColumns (8192) cells of the screen
// memory, and no item is taken meanwhile. An SGR sequence holds the parser
// while it applies each stored parameter in turn, then queues its command.
// ----------------------------------------------------------------------------
module ansi_csi_text_screen_top import acts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  in_item_t            in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output out_item_t           out_data_o,
  input  logic                out_stall_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic push, pop, q_full, q_empty, hold;
  cmd_t push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  acts_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .in_stall_o(in_stall_o),
    .hold_i    (hold),
    .q_full_i  (q_full),
    .push_o    (push),
    .push_cmd_o(push_cmd)
  );

  acts_cmd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (head_cmd),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  acts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_empty_i  (q_empty),
    .q_head_i   (head_cmd),
    .pop_o      (pop),
    .hold_o     (hold),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
